// ----- src/dec86_pkg.sv -----
// dec86_pkg: form codes, opcode table and record type for the 8086 subset decoder
`timescale 1ns / 1ps

package dec86_pkg;

    // instruction form codes, in table order
    localparam logic [5:0] K_MOV_RM       = 6'd0;
    localparam logic [5:0] K_MOV_IMM_RM   = 6'd1;
    localparam logic [5:0] K_MOV_IMM_REG  = 6'd2;
    localparam logic [5:0] K_MOV_MEM_ACC  = 6'd3;
    localparam logic [5:0] K_MOV_ACC_MEM  = 6'd4;
    localparam logic [5:0] K_ADD_RM       = 6'd5;
    localparam logic [5:0] K_ADD_IMM_RM   = 6'd6;
    localparam logic [5:0] K_ADD_IMM_ACC  = 6'd7;
    localparam logic [5:0] K_SUB_RM       = 6'd8;
    localparam logic [5:0] K_SUB_IMM_RM   = 6'd9;
    localparam logic [5:0] K_SUB_IMM_ACC  = 6'd10;
    localparam logic [5:0] K_CMP_RM       = 6'd11;
    localparam logic [5:0] K_CMP_IMM_RM   = 6'd12;
    localparam logic [5:0] K_CMP_IMM_ACC  = 6'd13;
    localparam logic [5:0] K_JUMP_BASE    = 6'd14;
    localparam logic [5:0] K_LAST         = 6'd33;
    localparam logic [5:0] FORM_GROUP     = 6'd62;
    localparam logic [5:0] FORM_NONE      = 6'd63;

    // group sub-op codes in the ModRM reg field
    localparam logic [2:0] SUB_OP_ADD = 3'd0;
    localparam logic [2:0] SUB_OP_SUB = 3'd5;
    localparam logic [2:0] SUB_OP_CMP = 3'd7;

    localparam logic [1:0] MOD_NO_DISP = 2'd0;
    localparam logic [1:0] MOD_DISP8   = 2'd1;
    localparam logic [1:0] MOD_DISP16  = 2'd2;
    localparam logic [2:0] RM_DIRECT   = 3'd6;

    localparam int NUM_JUMPS = 20;
    localparam logic [7:0] JUMP_CODES [NUM_JUMPS] = '{
        8'h74, 8'h7C, 8'h7E, 8'h72, 8'h76, 8'h7A, 8'h70, 8'h78, 8'h75, 8'h7D,
        8'h7F, 8'h73, 8'h77, 8'h7B, 8'h71, 8'h79, 8'hE2, 8'hE1, 8'hE0, 8'hE3
    };

    typedef struct packed {
        logic        invalid;
        logic [5:0]  kind;
        logic        wide;
        logic        direction;
        logic        sign_ext;
        logic [1:0]  mode;
        logic [2:0]  reg_field;
        logic [2:0]  rm_field;
        logic [15:0] displacement;
        logic [15:0] operand_value;
        logic [2:0]  length;
    } t_record;

    // first-match opcode table
    function automatic logic [5:0] classify(input logic [7:0] b);
        logic [5:0] f;
        f = FORM_NONE;
        if      ((b & 8'hFC) == 8'h88) f = K_MOV_RM;
        else if ((b & 8'hFE) == 8'hC6) f = K_MOV_IMM_RM;
        else if ((b & 8'hF0) == 8'hB0) f = K_MOV_IMM_REG;
        else if ((b & 8'hFE) == 8'hA0) f = K_MOV_MEM_ACC;
        else if ((b & 8'hFE) == 8'hA2) f = K_MOV_ACC_MEM;
        else if ((b & 8'hFC) == 8'h00) f = K_ADD_RM;
        else if ((b & 8'hFC) == 8'h80) f = FORM_GROUP;
        else if ((b & 8'hFE) == 8'h04) f = K_ADD_IMM_ACC;
        else if ((b & 8'hFC) == 8'h28) f = K_SUB_RM;
        else if ((b & 8'hFE) == 8'h2C) f = K_SUB_IMM_ACC;
        else if ((b & 8'hFC) == 8'h38) f = K_CMP_RM;
        else if ((b & 8'hFE) == 8'h3C) f = K_CMP_IMM_ACC;
        else begin
            for (int i = 0; i < NUM_JUMPS; i++) begin
                if (f == FORM_NONE && JUMP_CODES[i] == b) begin
                    f = K_JUMP_BASE + 6'(i);
                end
            end
        end
        return f;
    endfunction

    function automatic logic is_regmem(input logic [5:0] f);
        return (f == K_ADD_RM) || (f == K_MOV_RM) || (f == K_SUB_RM) || (f == K_CMP_RM);
    endfunction

    function automatic logic is_group(input logic [5:0] f);
        return (f == K_ADD_IMM_RM) || (f == K_SUB_IMM_RM) || (f == K_CMP_IMM_RM);
    endfunction

    function automatic logic has_modrm(input logic [5:0] f);
        return is_regmem(f) || is_group(f) || (f == K_MOV_IMM_RM) || (f == FORM_GROUP);
    endfunction

    function automatic logic [15:0] sext8(input logic [7:0] v);
        return {{8{v[7]}}, v};
    endfunction

endpackage

// ----- src/decoder_8086_subset.sv -----
// decoder_8086_subset: byte-serial decoder for a subset of 8086 instructions
`timescale 1ns / 1ps

//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+----------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_code_byte
//  out     | output    | o_out_valid / i_out_ready | o_invalid .. o_length (one record)
//
// one code word is taken per cycle while o_in_ready is high; the decode step and the state update sit
// between the state registers and the record register
// a record appears in the cycle after the word that finishes its instruction
// synchronous active-low reset returns to the opcode phase with no record held
// the input stalls only while a record is held and the output is not ready

module decoder_8086_subset (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_code_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_invalid,
    output logic [5:0]         o_kind,
    output logic               o_wide,
    output logic               o_direction,
    output logic               o_sign_ext,
    output logic [1:0]         o_mode,
    output logic [2:0]         o_reg_field,
    output logic [2:0]         o_rm_field,
    output logic signed [15:0] o_displacement,
    output logic [15:0]        o_operand_value,
    output logic [2:0]         o_length
);

    typedef enum logic [3:0] {
        PH_OPCODE = 4'b0001,
        PH_MODRM  = 4'b0010,
        PH_DISP   = 4'b0100,
        PH_IMM    = 4'b1000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [5:0]  r_form, n_form;
    logic [7:0]  r_opcode, n_opcode;
    logic [7:0]  r_modrm, n_modrm;
    logic [15:0] r_disp, n_disp;
    logic [15:0] r_imm, n_imm;
    logic [1:0]  r_left, n_left;
    logic [2:0]  r_count, n_count;
    logic [1:0]  r_dlen, n_dlen;
    logic [1:0]  r_ilen, n_ilen;

    dec86_pkg::t_record r_rec, n_rec;
    logic               r_out_valid;

    logic       w_accept;
    logic       w_emit;
    logic       w_bad;
    logic [5:0] w_class;
    logic [5:0] w_grp_form;
    logic [1:0] w_dpos;
    logic [1:0] w_ipos;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_class    = dec86_pkg::classify(i_code_byte);
    assign w_dpos     = r_dlen - r_left;
    assign w_ipos     = r_ilen - r_left;

    // next state for the accepted word
    always_comb begin
        n_phase    = r_phase;
        n_form     = r_form;
        n_opcode   = r_opcode;
        n_modrm    = r_modrm;
        n_disp     = r_disp;
        n_imm      = r_imm;
        n_left     = r_left;
        n_count    = r_count + 3'd1;
        n_dlen     = r_dlen;
        n_ilen     = r_ilen;
        w_emit     = 1'b0;
        w_bad      = 1'b0;
        w_grp_form = r_form;
        unique case (r_phase)
            PH_OPCODE: begin
                n_opcode = i_code_byte;
                n_count  = 3'd1;
                n_form   = '0;
                n_modrm  = '0;
                n_disp   = '0;
                n_imm    = '0;
                n_left   = '0;
                n_dlen   = '0;
                n_ilen   = '0;
                if (w_class == dec86_pkg::FORM_NONE) begin
                    w_bad = 1'b1;
                end else begin
                    n_form = w_class;
                    if (dec86_pkg::has_modrm(w_class)) begin
                        n_phase = PH_MODRM;
                    end else begin
                        if (w_class == dec86_pkg::K_MOV_MEM_ACC ||
                            w_class == dec86_pkg::K_MOV_ACC_MEM) begin
                            n_ilen = 2'd2;
                        end else if (w_class == dec86_pkg::K_MOV_IMM_REG) begin
                            n_ilen = i_code_byte[3] ? 2'd2 : 2'd1;
                        end else if (w_class < dec86_pkg::K_JUMP_BASE) begin
                            n_ilen = i_code_byte[0] ? 2'd2 : 2'd1;
                        end else begin
                            n_ilen = 2'd1;
                        end
                        n_phase = PH_IMM;
                        n_left  = n_ilen;
                    end
                end
            end
            PH_MODRM: begin
                n_modrm = i_code_byte;
                if (r_form == dec86_pkg::FORM_GROUP) begin
                    unique case (i_code_byte[5:3])
                        dec86_pkg::SUB_OP_ADD: w_grp_form = dec86_pkg::K_ADD_IMM_RM;
                        dec86_pkg::SUB_OP_SUB: w_grp_form = dec86_pkg::K_SUB_IMM_RM;
                        dec86_pkg::SUB_OP_CMP: w_grp_form = dec86_pkg::K_CMP_IMM_RM;
                        default:               w_bad      = 1'b1;
                    endcase
                end
                if (w_bad) begin
                    n_phase = PH_OPCODE;
                end else begin
                    n_form = w_grp_form;
                    if (i_code_byte[7:6] == dec86_pkg::MOD_NO_DISP &&
                        i_code_byte[2:0] == dec86_pkg::RM_DIRECT) begin
                        n_dlen = 2'd2;
                    end else if (i_code_byte[7:6] == dec86_pkg::MOD_DISP8) begin
                        n_dlen = 2'd1;
                    end else if (i_code_byte[7:6] == dec86_pkg::MOD_DISP16) begin
                        n_dlen = 2'd2;
                    end else begin
                        n_dlen = 2'd0;
                    end
                    if (w_grp_form == dec86_pkg::K_MOV_IMM_RM) begin
                        n_ilen = r_opcode[0] ? 2'd2 : 2'd1;
                    end else if (dec86_pkg::is_group(w_grp_form)) begin
                        n_ilen = (r_opcode[0] && !r_opcode[1]) ? 2'd2 : 2'd1;
                    end else begin
                        n_ilen = 2'd0;
                    end
                    if (n_dlen != 2'd0) begin
                        n_phase = PH_DISP;
                        n_left  = n_dlen;
                    end else if (n_ilen != 2'd0) begin
                        n_phase = PH_IMM;
                        n_left  = n_ilen;
                    end else begin
                        w_emit  = 1'b1;
                        n_phase = PH_OPCODE;
                    end
                end
            end
            PH_DISP: begin
                if (w_dpos[0]) n_disp[15:8] = i_code_byte;
                else           n_disp[7:0]  = i_code_byte;
                n_left = r_left - 2'd1;
                if (n_left == 2'd0) begin
                    if (r_ilen != 2'd0) begin
                        n_phase = PH_IMM;
                        n_left  = r_ilen;
                    end else begin
                        w_emit  = 1'b1;
                        n_phase = PH_OPCODE;
                    end
                end
            end
            PH_IMM: begin
                if (w_ipos[0]) n_imm[15:8] = i_code_byte;
                else           n_imm[7:0]  = i_code_byte;
                if (r_left != 2'd0) n_left = r_left - 2'd1;
                if (n_left == 2'd0) begin
                    w_emit  = 1'b1;
                    n_phase = PH_OPCODE;
                end
            end
            default: begin
                n_phase = PH_OPCODE;
            end
        endcase
    end

    // record built from the updated state
    always_comb begin
        n_rec        = '0;
        n_rec.length = n_count;
        if (w_bad) begin
            n_rec.invalid = 1'b1;
        end else begin
            n_rec.kind = n_form;
            if (n_form == dec86_pkg::K_MOV_IMM_REG) n_rec.wide = n_opcode[3];
            else if (n_form < dec86_pkg::K_JUMP_BASE) n_rec.wide = n_opcode[0];
            if (dec86_pkg::is_regmem(n_form)) n_rec.direction = n_opcode[1];
            if (dec86_pkg::is_group(n_form))  n_rec.sign_ext  = n_opcode[1];
            if (dec86_pkg::has_modrm(n_form)) begin
                n_rec.mode      = n_modrm[7:6];
                n_rec.reg_field = n_modrm[5:3];
                n_rec.rm_field  = n_modrm[2:0];
            end else if (n_form == dec86_pkg::K_MOV_IMM_REG) begin
                n_rec.reg_field = n_opcode[2:0];
            end
            if (n_dlen == 2'd1)      n_rec.displacement = dec86_pkg::sext8(n_disp[7:0]);
            else if (n_dlen == 2'd2) n_rec.displacement = n_disp;
            if (n_ilen == 2'd1) begin
                n_rec.operand_value = (n_form == dec86_pkg::K_MOV_IMM_REG)
                                    ? {8'h00, n_imm[7:0]}
                                    : dec86_pkg::sext8(n_imm[7:0]);
            end else if (n_ilen == 2'd2) begin
                n_rec.operand_value = n_imm;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_OPCODE;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase <= n_phase;
                r_left  <= n_left;
            end
            if (w_accept && (w_emit || w_bad)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_form   <= n_form;
            r_opcode <= n_opcode;
            r_modrm  <= n_modrm;
            r_disp   <= n_disp;
            r_imm    <= n_imm;
            r_count  <= n_count;
            r_dlen   <= n_dlen;
            r_ilen   <= n_ilen;
        end
        if (w_accept && (w_emit || w_bad)) begin
            r_rec <= n_rec;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_invalid       = r_rec.invalid;
    assign o_kind          = r_rec.kind;
    assign o_wide          = r_rec.wide;
    assign o_direction     = r_rec.direction;
    assign o_sign_ext      = r_rec.sign_ext;
    assign o_mode          = r_rec.mode;
    assign o_reg_field     = r_rec.reg_field;
    assign o_rm_field      = r_rec.rm_field;
    assign o_displacement  = $signed(r_rec.displacement);
    assign o_operand_value = r_rec.operand_value;
    assign o_length        = r_rec.length;

    // no field bytes owed while waiting for an opcode
    a_idle_no_bytes_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_OPCODE) |-> (r_left == 2'd0))
        else $error("bytes still owed in opcode phase");

    // field phases always owe at least one byte
    a_field_owes_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DISP || r_phase == PH_IMM) |-> (r_left != 2'd0))
        else $error("field phase with no bytes owed");

    // an opcode word restarts the byte count
    a_opcode_restarts_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_phase == PH_OPCODE) |=> (r_count == 3'd1))
        else $error("byte count not restarted at opcode");

    // a good record always spans at least two words and has a kind no higher than K_LAST
    a_valid_record_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_rec.invalid) |-> (r_rec.length >= 3'd2 &&
                                             r_rec.kind <= dec86_pkg::K_LAST))
        else $error("bad length or kind on a good record");

    // an invalid record carries nothing but its length
    a_invalid_record_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rec.invalid) |-> (r_rec.kind == 6'd0 &&
                                            r_rec.displacement == 16'd0 &&
                                            r_rec.operand_value == 16'd0))
        else $error("invalid record carries field data");

endmodule

// ----- verif/tb.sv -----
// tb: self-checking bench for the byte-serial 8086 subset decoder
`timescale 1ns / 1ps

module tb;

    typedef enum logic [1:0] {PH_OPCODE, PH_MODRM, PH_DISP, PH_IMM} t_dec_phase;

    localparam int N_DIRECTED = 27;
    localparam int N_RANDOM   = 400;
    localparam int CHUNK      = 100;

    // per idling phase: sender gap and receiver stall, in percent
    localparam int SEND_GAP_PCT [4] = '{0, 57, 0, 32};
    localparam int STALL_PCT    [4] = '{0, 0, 57, 32};

    // code word, then the length of the invalid record it closes (0: left to the decode model)
    localparam logic [10:0] DIRECTED_ROWS [N_DIRECTED] = '{
        {8'hFF, 3'd1},
        {8'h80, 3'd0}, {8'h08, 3'd2},
        {8'h81, 3'd0}, {8'h87, 3'd0}, {8'hFF, 3'd0}, {8'h7F, 3'd0}, {8'h00, 3'd0},
        {8'h80, 3'd0},
        {8'h83, 3'd0}, {8'h6E, 3'd0}, {8'h80, 3'd0}, {8'hFF, 3'd0},
        {8'h8B, 3'd0}, {8'hC1, 3'd0},
        {8'hC6, 3'd0}, {8'h38, 3'd0}, {8'h7F, 3'd0},
        {8'hB4, 3'd0}, {8'h80, 3'd0},
        {8'hA3, 3'd0}, {8'hFF, 3'd0}, {8'hFF, 3'd0},
        {8'h74, 3'd0}, {8'h80, 3'd0},
        {8'hE3, 3'd0}, {8'h7F, 3'd0}
    };

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic [7:0]         i_code_byte = 8'h00;
    logic               i_out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic               o_invalid;
    logic [5:0]         o_kind;
    logic               o_wide;
    logic               o_direction;
    logic               o_sign_ext;
    logic [1:0]         o_mode;
    logic [2:0]         o_reg_field;
    logic [2:0]         o_rm_field;
    logic signed [15:0] o_displacement;
    logic [15:0]        o_operand_value;
    logic [2:0]         o_length;

    decoder_8086_subset dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_code_byte     (i_code_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_invalid       (o_invalid),
        .o_kind          (o_kind),
        .o_wide          (o_wide),
        .o_direction     (o_direction),
        .o_sign_ext      (o_sign_ext),
        .o_mode          (o_mode),
        .o_reg_field     (o_reg_field),
        .o_rm_field      (o_rm_field),
        .o_displacement  (o_displacement),
        .o_operand_value (o_operand_value),
        .o_length        (o_length)
    );

    logic [10:0]        stim_rows [$];
    dec86_pkg::t_record pending_records [$];
    int                 mismatches = 0;
    int                 idle_mode = 0;

    // decode model state
    t_dec_phase  dec_phase = PH_OPCODE;
    logic [5:0]  dec_form;
    logic [7:0]  dec_opcode;
    logic [7:0]  dec_modrm;
    logic [15:0] dec_disp;
    logic [15:0] dec_imm;
    logic [2:0]  dec_left;
    logic [2:0]  dec_count;
    logic [1:0]  dec_disp_len;
    logic [1:0]  dec_imm_len;

    function automatic logic [5:0] form_of(input logic [7:0] b);
        logic [5:0] f;
        f = dec86_pkg::FORM_NONE;
        casez (b)
            8'b1000_10??: f = dec86_pkg::K_MOV_RM;
            8'b1100_011?: f = dec86_pkg::K_MOV_IMM_RM;
            8'b1011_????: f = dec86_pkg::K_MOV_IMM_REG;
            8'b1010_000?: f = dec86_pkg::K_MOV_MEM_ACC;
            8'b1010_001?: f = dec86_pkg::K_MOV_ACC_MEM;
            8'b0000_00??: f = dec86_pkg::K_ADD_RM;
            8'b1000_00??: f = dec86_pkg::FORM_GROUP;
            8'b0000_010?: f = dec86_pkg::K_ADD_IMM_ACC;
            8'b0010_10??: f = dec86_pkg::K_SUB_RM;
            8'b0010_110?: f = dec86_pkg::K_SUB_IMM_ACC;
            8'b0011_10??: f = dec86_pkg::K_CMP_RM;
            8'b0011_110?: f = dec86_pkg::K_CMP_IMM_ACC;
            default: begin
                for (int i = 0; i < dec86_pkg::NUM_JUMPS; i++) begin
                    if (dec86_pkg::JUMP_CODES[i] == b) f = dec86_pkg::K_JUMP_BASE + 6'(i);
                end
            end
        endcase
        return f;
    endfunction

    function automatic logic reg_mem_form(input logic [5:0] f);
        return f == dec86_pkg::K_MOV_RM || f == dec86_pkg::K_ADD_RM ||
               f == dec86_pkg::K_SUB_RM || f == dec86_pkg::K_CMP_RM;
    endfunction

    function automatic logic imm_group_form(input logic [5:0] f);
        return f == dec86_pkg::K_ADD_IMM_RM || f == dec86_pkg::K_SUB_IMM_RM ||
               f == dec86_pkg::K_CMP_IMM_RM;
    endfunction

    function automatic logic modrm_form(input logic [5:0] f);
        return reg_mem_form(f) || imm_group_form(f) || f == dec86_pkg::K_MOV_IMM_RM ||
               f == dec86_pkg::FORM_GROUP;
    endfunction

    // move on to the next owed field; 1 when the instruction is complete
    function automatic logic next_field();
        if (dec_phase < PH_DISP && dec_disp_len != 2'd0) begin
            dec_phase = PH_DISP;
            dec_left  = 3'(dec_disp_len);
            return 1'b0;
        end
        if (dec_phase < PH_IMM && dec_imm_len != 2'd0) begin
            dec_phase = PH_IMM;
            dec_left  = 3'(dec_imm_len);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic decode_code_word(input logic [7:0] b, output logic done,
                                    output dec86_pkg::t_record rec);
        logic bad;
        logic [2:0] sub;
        bad  = 1'b0;
        done = 1'b0;
        rec  = '0;
        if (dec_phase == PH_OPCODE) begin
            dec_form     = form_of(b);
            dec_opcode   = b;
            dec_modrm    = 8'h00;
            dec_disp     = 16'h0000;
            dec_imm      = 16'h0000;
            dec_left     = 3'd0;
            dec_count    = 3'd1;
            dec_disp_len = 2'd0;
            dec_imm_len  = 2'd0;
            if (dec_form == dec86_pkg::FORM_NONE) begin
                bad = 1'b1;
            end else if (modrm_form(dec_form)) begin
                dec_phase = PH_MODRM;
            end else begin
                if (dec_form == dec86_pkg::K_MOV_MEM_ACC ||
                    dec_form == dec86_pkg::K_MOV_ACC_MEM) dec_imm_len = 2'd2;
                else if (dec_form == dec86_pkg::K_MOV_IMM_REG) dec_imm_len = b[3] ? 2'd2 : 2'd1;
                else if (dec_form < dec86_pkg::K_JUMP_BASE) dec_imm_len = b[0] ? 2'd2 : 2'd1;
                else dec_imm_len = 2'd1;
                done = next_field();
            end
        end else begin
            dec_count = dec_count + 3'd1;
            case (dec_phase)
                PH_MODRM: begin
                    sub       = b[5:3];
                    dec_modrm = b;
                    if (dec_form == dec86_pkg::FORM_GROUP) begin
                        if (sub == dec86_pkg::SUB_OP_ADD) dec_form = dec86_pkg::K_ADD_IMM_RM;
                        else if (sub == dec86_pkg::SUB_OP_SUB) dec_form = dec86_pkg::K_SUB_IMM_RM;
                        else if (sub == dec86_pkg::SUB_OP_CMP) dec_form = dec86_pkg::K_CMP_IMM_RM;
                        else bad = 1'b1;
                    end
                    if (!bad) begin
                        if (b[7:6] == dec86_pkg::MOD_NO_DISP &&
                            b[2:0] == dec86_pkg::RM_DIRECT) dec_disp_len = 2'd2;
                        else if (b[7:6] == dec86_pkg::MOD_DISP8) dec_disp_len = 2'd1;
                        else if (b[7:6] == dec86_pkg::MOD_DISP16) dec_disp_len = 2'd2;
                        else dec_disp_len = 2'd0;
                        if (dec_form == dec86_pkg::K_MOV_IMM_RM) begin
                            dec_imm_len = dec_opcode[0] ? 2'd2 : 2'd1;
                        end else if (imm_group_form(dec_form)) begin
                            // two bytes only for w=1 with s=0
                            dec_imm_len = (dec_opcode[0] && !dec_opcode[1]) ? 2'd2 : 2'd1;
                        end else begin
                            dec_imm_len = 2'd0;
                        end
                        done = next_field();
                    end
                end
                PH_DISP: begin
                    if (dec_left == 3'(dec_disp_len)) dec_disp[7:0] = b;
                    else dec_disp[15:8] = b;
                    dec_left = dec_left - 3'd1;
                    if (dec_left == 3'd0) done = next_field();
                end
                default: begin
                    if (dec_left == 3'(dec_imm_len)) dec_imm[7:0] = b;
                    else dec_imm[15:8] = b;
                    if (dec_left != 3'd0) dec_left = dec_left - 3'd1;
                    if (dec_left == 3'd0) done = 1'b1;
                end
            endcase
        end
        if (bad) begin
            rec.invalid = 1'b1;
            rec.length  = dec_count;
            dec_phase   = PH_OPCODE;
            done        = 1'b1;
        end else if (done) begin
            rec.kind = dec_form;
            if (dec_form == dec86_pkg::K_MOV_IMM_REG) rec.wide = dec_opcode[3];
            else if (dec_form < dec86_pkg::K_JUMP_BASE) rec.wide = dec_opcode[0];
            if (reg_mem_form(dec_form)) rec.direction = dec_opcode[1];
            if (imm_group_form(dec_form)) rec.sign_ext = dec_opcode[1];
            if (modrm_form(dec_form)) begin
                rec.mode      = dec_modrm[7:6];
                rec.reg_field = dec_modrm[5:3];
                rec.rm_field  = dec_modrm[2:0];
            end else if (dec_form == dec86_pkg::K_MOV_IMM_REG) begin
                rec.reg_field = dec_opcode[2:0];
            end
            if (dec_disp_len == 2'd1) rec.displacement = {{8{dec_disp[7]}}, dec_disp[7:0]};
            else if (dec_disp_len == 2'd2) rec.displacement = dec_disp;
            if (dec_imm_len == 2'd1) begin
                // the register immediate is zero-extended, every other one sign-extended
                rec.operand_value = (dec_form == dec86_pkg::K_MOV_IMM_REG)
                                  ? {8'h00, dec_imm[7:0]}
                                  : {{8{dec_imm[7]}}, dec_imm[7:0]};
            end else if (dec_imm_len == 2'd2) begin
                rec.operand_value = dec_imm;
            end
            rec.length = dec_count;
            dec_phase  = PH_OPCODE;
        end
    endtask

    // mostly whole instructions with random content, some noise and cut-off ones
    task automatic queue_instruction();
        logic [7:0] op;
        logic [7:0] modrm;
        logic [5:0] f;
        logic [7:0] words [$];
        int roll;
        int n_extra;
        int keep;
        int pick;
        roll    = $urandom_range(0, 99);
        n_extra = 0;
        if (roll < 8) begin
            words.push_back(8'($urandom));
        end else if (roll < 14) begin
            // group opcode with a sub-op outside add, sub and cmp
            pick  = $urandom_range(0, 4);
            modrm = 8'($urandom);
            modrm[5:3] = (pick == 4) ? 3'd6 : 3'(pick + 1);
            words.push_back(8'h80 | 8'($urandom_range(0, 3)));
            words.push_back(modrm);
        end else begin
            do op = 8'($urandom); while (form_of(op) == dec86_pkg::FORM_NONE);
            f = form_of(op);
            words.push_back(op);
            if (modrm_form(f)) begin
                modrm = 8'($urandom);
                if (f == dec86_pkg::FORM_GROUP) begin
                    pick = $urandom_range(0, 2);
                    modrm[5:3] = (pick == 0) ? dec86_pkg::SUB_OP_ADD :
                                 (pick == 1) ? dec86_pkg::SUB_OP_SUB : dec86_pkg::SUB_OP_CMP;
                end
                words.push_back(modrm);
                if (modrm[7:6] == dec86_pkg::MOD_NO_DISP &&
                    modrm[2:0] == dec86_pkg::RM_DIRECT) n_extra = 2;
                else if (modrm[7:6] == dec86_pkg::MOD_DISP8) n_extra = 1;
                else if (modrm[7:6] == dec86_pkg::MOD_DISP16) n_extra = 2;
                if (f == dec86_pkg::K_MOV_IMM_RM) n_extra += op[0] ? 2 : 1;
                else if (f == dec86_pkg::FORM_GROUP) n_extra += (op[0] && !op[1]) ? 2 : 1;
            end else begin
                if (f == dec86_pkg::K_MOV_MEM_ACC || f == dec86_pkg::K_MOV_ACC_MEM) n_extra = 2;
                else if (f == dec86_pkg::K_MOV_IMM_REG) n_extra = op[3] ? 2 : 1;
                else if (f < dec86_pkg::K_JUMP_BASE) n_extra = op[0] ? 2 : 1;
                else n_extra = 1;
            end
            repeat (n_extra) words.push_back(8'($urandom));
        end
        keep = words.size();
        if (roll >= 14 && roll < 19 && keep > 1) keep = $urandom_range(1, keep - 1);
        for (int i = 0; i < keep; i++) stim_rows.push_back({words[i], 3'd0});
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("decoder_8086_subset regression: fail");
        $finish;
    end

    // output side: random stalls, every record checked against the oldest expectation
    initial begin
        dec86_pkg::t_record got;
        dec86_pkg::t_record want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got = {o_invalid, o_kind, o_wide, o_direction, o_sign_ext, o_mode,
                       o_reg_field, o_rm_field, o_displacement, o_operand_value, o_length};
                if (pending_records.size() == 0) begin
                    $display("%0t: record expected none actual %h", $time, got);
                    mismatches++;
                end else begin
                    want = pending_records.pop_front();
                    check_field("invalid", 16'(want.invalid), 16'(got.invalid));
                    check_field("kind", 16'(want.kind), 16'(got.kind));
                    check_field("wide", 16'(want.wide), 16'(got.wide));
                    check_field("direction", 16'(want.direction), 16'(got.direction));
                    check_field("sign_ext", 16'(want.sign_ext), 16'(got.sign_ext));
                    check_field("mode", 16'(want.mode), 16'(got.mode));
                    check_field("reg_field", 16'(want.reg_field), 16'(got.reg_field));
                    check_field("rm_field", 16'(want.rm_field), 16'(got.rm_field));
                    check_field("displacement", want.displacement, got.displacement);
                    check_field("operand_value", want.operand_value, got.operand_value);
                    check_field("length", 16'(want.length), 16'(got.length));
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= STALL_PCT[idle_mode]);
        end
    end

    initial begin
        int k;
        logic [7:0] b;
        logic [2:0] bad_len;
        logic done;
        dec86_pkg::t_record rec;
        for (k = 0; k < N_DIRECTED; k++) stim_rows.push_back(DIRECTED_ROWS[k]);
        while (stim_rows.size() < N_DIRECTED + N_RANDOM) queue_instruction();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < stim_rows.size(); k++) begin
            {b, bad_len} = stim_rows[k];
            idle_mode = (k < N_DIRECTED) ? 0 : ((k - N_DIRECTED) / CHUNK + 1) % 4;
            while ($urandom_range(0, 99) < SEND_GAP_PCT[idle_mode]) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_in_valid  <= 1'b1;
            i_code_byte <= b;
            do @(posedge i_clk); while (!o_in_ready);
            // word taken at this edge
            decode_code_word(b, done, rec);
            if (done) begin
                if (bad_len != 3'd0) begin
                    rec         = '0;
                    rec.invalid = 1'b1;
                    rec.length  = bad_len;
                end
                pending_records.push_back(rec);
            end
        end
        i_in_valid <= 1'b0;

        while (pending_records.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_records.size() == 0) begin
            $display("decoder_8086_subset regression: pass");
        end else begin
            $display("decoder_8086_subset regression: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/dec86_pkg.sv
src/decoder_8086_subset.sv
verif/tb.sv
